// ===== rtl/lpht_pkg.sv =====
// Shared types and constants for the linear-probe hash table.
// Used by the front, back and top-level modules; depends on nothing.
package lpht_pkg;

  // Operation codes carried in the input tuser bit
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Murmur3 32-bit finaliser constants
  localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;
  localparam int unsigned MIX_S1 = 16;
  localparam int unsigned MIX_S2 = 13;

  // One request as it travels from front to back
  typedef struct packed {
    logic        action;
    logic [31:0] key;
    logic [31:0] value;
  } item_t;

  localparam int unsigned ITEM_W = $bits(item_t);

endpackage

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear-probe hash table: front, queue and back.
// Depends on lpht_pkg, lpht_front, lpht_fifo and lpht_back.
//
//   channel   dir  tdata                       tuser
//   s_axis    in   [31:0] key, [63:32] value   [0] action (0 get, 1 put)
//   m_axis    out  [31:0] result_value         [0] hit, [1] full_res
//
// Hashing steps each item through two registered multiplies in the front;
// the front takes no new item until the last one is pushed to the queue.
// The back takes an item, then visits each probed slot in two states
// (registered memory read, then compare). After reset every key store slot
// is swept clear; s_axis is held off until the sweep ends. A stalled m_axis
// holds its result; the front and queue keep taking items until the queue fills.
module linear_probe_hash_table #(
  parameter int unsigned INDEX_BITS  = 10,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key, value
  input  logic [0:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_value
  output logic [1:0]  m_axis_tuser   // hit, full_res
);

  localparam int unsigned QW = lpht_pkg::ITEM_W + INDEX_BITS;

  lpht_pkg::item_t in_item;
  logic            clearing;
  logic            f_valid;
  logic            f_ready;
  logic [QW-1:0]   f_data;
  logic            b_valid;
  logic            b_ready;
  logic [QW-1:0]   b_data;
  logic            out_hit;
  logic            out_full;

  assign in_item.action = s_axis_tuser[0];
  assign in_item.key    = s_axis_tdata[31:0];
  assign in_item.value  = s_axis_tdata[63:32];
  assign m_axis_tuser   = {out_full, out_hit};

  lpht_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (clearing),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  lpht_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  lpht_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_data    (b_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_hit   (out_hit),
    .out_full  (out_full),
    .out_value (m_axis_tdata)
  );

`ifndef SYNTH
  // No transfer in either direction while the key store is being cleared
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("input accepted during clearing sweep");

  a_no_output_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !m_axis_tvalid)
    else $error("result presented during clearing sweep");

  // A hit never comes with a rejection
  a_hit_not_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("hit and full flagged together");

  // A miss or rejection carries a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
    else $error("non-zero value on a miss");
`endif

endmodule

// ===== rtl/lpht_fifo.sv =====
// Short queue between the hashing front and the probing back.
// Generic width; no package dependency.
module lpht_fifo #(
  parameter int unsigned WIDTH = 75,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W:0]   wr_ptr;
  logic [PTR_W:0]   rd_ptr;
  logic             empty;
  logic             full;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[PTR_W] != rd_ptr[PTR_W]) &&
                 (wr_ptr[PTR_W-1:0] == rd_ptr[PTR_W-1:0]);

  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_data   = store[rd_ptr[PTR_W-1:0]];

  // Advance pointers on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push_valid && push_ready) wr_ptr <= wr_ptr + 1'b1;
      if (pop_valid && pop_ready)   rd_ptr <= rd_ptr + 1'b1;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) store[wr_ptr[PTR_W-1:0]] <= push_data;
  end

endmodule

// ===== rtl/lpht_front.sv =====
// Front end: accepts requests and computes the murmur3 home slot.
// Depends on lpht_pkg; feeds lpht_fifo.
module lpht_front #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  hold,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  lpht_pkg::item_t                       in_item,
  output logic                                  q_valid,
  input  logic                                  q_ready,
  output logic [lpht_pkg::ITEM_W+INDEX_BITS-1:0] q_data
);

  typedef enum logic [1:0] {F_IDLE, F_MIX1, F_MIX2, F_PUSH} state_t;

  state_t          state;
  lpht_pkg::item_t item;
  logic [31:0]     h;
  logic [31:0]     h_fin;

  assign in_ready = (state == F_IDLE) && !hold;
  assign q_valid  = (state == F_PUSH);
  assign h_fin    = h ^ (h >> lpht_pkg::MIX_S1);
  assign q_data   = {h_fin[INDEX_BITS-1:0], item};

  // Sequence one item through the two multiply steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            item  <= in_item;
            h     <= in_item.key;
            state <= F_MIX1;
          end
        end
        F_MIX1: begin
          h     <= (h ^ (h >> lpht_pkg::MIX_S1)) * lpht_pkg::MIX_C1;
          state <= F_MIX2;
        end
        F_MIX2: begin
          h     <= (h ^ (h >> lpht_pkg::MIX_S2)) * lpht_pkg::MIX_C2;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lpht_back.sv =====
// Back end: clears the key store, probes slots and writes results.
// Depends on lpht_pkg; drains lpht_fifo and owns the key/value memories.
module lpht_back #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  output logic                                  clearing,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  logic [lpht_pkg::ITEM_W+INDEX_BITS-1:0] q_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_hit,
  output logic                                  out_full,
  output logic [31:0]                           out_value
);

  localparam int unsigned SLOTS = 1 << INDEX_BITS;

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_CMP} state_t;

  state_t                state;
  lpht_pkg::item_t       cur;
  lpht_pkg::item_t       q_item;
  logic [INDEX_BITS-1:0] slot;
  logic [INDEX_BITS-1:0] probes;
  logic [31:0]           key_mem [SLOTS];
  logic [31:0]           value_mem [SLOTS];
  logic [31:0]           key_q;
  logic [31:0]           val_q;
  logic                  out_free;
  logic                  match;
  logic                  empty_slot;
  logic                  store_now;
  logic                  key_we;

  assign q_item     = lpht_pkg::item_t'(q_data[lpht_pkg::ITEM_W-1:0]);
  assign clearing   = (state == B_CLEAR);
  assign out_free   = !out_valid || out_ready;
  assign q_ready    = (state == B_IDLE) && out_free;
  assign match      = (key_q == cur.key);
  assign empty_slot = (key_q == '0);
  assign store_now  = (state == B_CMP) && (match || empty_slot) &&
                      (cur.action == lpht_pkg::ACT_PUT);
  assign key_we     = clearing || store_now;

  // Key store: one write and one registered read at the current slot
  always_ff @(posedge clk) begin
    if (key_we) key_mem[slot] <= clearing ? 32'd0 : cur.key;
    key_q <= key_mem[slot];
  end

  // Value store
  always_ff @(posedge clk) begin
    if (store_now) value_mem[slot] <= cur.value;
    val_q <= value_mem[slot];
  end

  // Probe sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        B_CLEAR: begin
          slot <= slot + 1'b1;
          if (slot == {INDEX_BITS{1'b1}}) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid && q_ready) begin
            cur    <= q_item;
            slot   <= q_data[lpht_pkg::ITEM_W +: INDEX_BITS];
            probes <= '0;
            if (q_item.key == '0) begin
              // reserved key: get misses, put is rejected
              out_valid <= 1'b1;
              out_hit   <= 1'b0;
              out_value <= '0;
              out_full  <= (q_item.action == lpht_pkg::ACT_PUT);
            end else begin
              state <= B_READ;
            end
          end
        end
        B_READ: begin
          state <= B_CMP;
        end
        B_CMP: begin
          if (match) begin
            out_valid <= 1'b1;
            out_hit   <= 1'b1;
            out_value <= val_q;
            out_full  <= 1'b0;
            state     <= B_IDLE;
          end else if (empty_slot) begin
            out_valid <= 1'b1;
            out_hit   <= 1'b0;
            out_value <= '0;
            out_full  <= 1'b0;
            state     <= B_IDLE;
          end else if (probes == {INDEX_BITS{1'b1}}) begin
            // every slot visited: table full
            out_valid <= 1'b1;
            out_hit   <= 1'b0;
            out_value <= '0;
            out_full  <= (cur.action == lpht_pkg::ACT_PUT);
            state     <= B_IDLE;
          end else begin
            slot   <= slot + 1'b1;
            probes <= probes + 1'b1;
            state  <= B_READ;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
